@@ rtl/cwb_pkg.sv @@
// Shared types and codes of the coalescing write buffer.
// Used by cwb_front, cwb_engine, cwb_result_q and coalescing_write_buffer.
`default_nettype none

package cwb_pkg;

  // Width of the address fields on the ports.
  localparam int unsigned LINE_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CHECK  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_DRAIN  = 2'd3
  } op_e;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_REPLY = 1'b1
  } kind_e;

  // Classified command passed from the front to the engine.
  typedef struct packed {
    op_e               op;
    logic [LINE_W-1:0] addr;
    logic              write_out;
  } cmd_t;

  // One result word.
  typedef struct packed {
    kind_e             kind;
    logic [LINE_W-1:0] addr;
    logic              hit;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/cwb_front.sv @@
// Front of the coalescing write buffer: accepts input words, decodes the
// command and holds them in a two-entry queue. Depends on cwb_pkg.
`default_nettype none

module cwb_front
  import cwb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire logic [1:0]        command_i,
  input  wire logic [LINE_W-1:0] line_address_i,
  input  wire logic              write_out_i,
  output logic                   cmd_valid_o,
  output cmd_t                   cmd_o,
  input  wire logic              cmd_pop_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  cmd_t       cmd_in;
  logic       do_push, do_pop;

  always_comb begin
    cmd_in.addr      = line_address_i;
    cmd_in.write_out = write_out_i;
    unique case (command_i)
      2'd0:    cmd_in.op = OP_INSERT;
      2'd1:    cmd_in.op = OP_CHECK;
      2'd2:    cmd_in.op = OP_CLEAR;
      default: cmd_in.op = OP_DRAIN;
    endcase
  end

  assign full_o      = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

@@ rtl/cwb_result_q.sv @@
// Two-entry result queue that parts the engine from the result ports.
// Depends on cwb_pkg.
`default_nettype none

module cwb_result_q
  import cwb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output res_t      data_o
);

  res_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

@@ rtl/cwb_engine.sv @@
// Back part of the coalescing write buffer: the shift register of line
// addresses, the parallel compare and the command sequencer. Depends on cwb_pkg.
`default_nettype none

module cwb_engine
  import cwb_pkg::*;
#(
  parameter int unsigned DEPTH        = 8,
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  input  wire logic res_full_i,
  output logic      res_push_o,
  output res_t      res_o
);

  localparam int unsigned IW = $clog2(DEPTH);

  typedef enum logic {
    ST_RUN,
    ST_REPLY
  } state_e;

  function automatic logic [ADDRESS_BITS-1:0] from_line(input logic [LINE_W-1:0] a);
    logic [ADDRESS_BITS+LINE_W-1:0] ext;
    ext = {{ADDRESS_BITS{1'b0}}, a};
    return ext[ADDRESS_BITS-1:0];
  endfunction

  function automatic logic [LINE_W-1:0] to_line(input logic [ADDRESS_BITS-1:0] a);
    logic [ADDRESS_BITS+LINE_W-1:0] ext;
    ext = {{LINE_W{1'b0}}, a};
    return ext[LINE_W-1:0];
  endfunction

  logic [ADDRESS_BITS-1:0] addr_q [DEPTH];
  logic [DEPTH-1:0]        valid_q, valid_d;
  state_e                  state_q, state_d;
  logic [LINE_W-1:0]       reply_addr_q, reply_addr_d;

  logic [ADDRESS_BITS-1:0] cmd_addr;
  logic [DEPTH-1:0]        match;
  logic                    any_match, any_valid, more_valid;
  logic [IW-1:0]           match_idx, first_idx;
  logic                    go;
  logic                    shift_en, tail_wr, clr_en;
  logic [IW-1:0]           shift_base;

  assign cmd_addr = from_line(cmd_i.addr);
  assign go       = cmd_valid_i && !res_full_i;

  // Parallel compare and lowest-index searches.
  always_comb begin
    match_idx = '0;
    first_idx = '0;
    for (int j = DEPTH - 1; j >= 0; j--) begin
      match[j] = valid_q[j] && (addr_q[j] == cmd_addr);
      if (match[j])   match_idx = IW'(j);
      if (valid_q[j]) first_idx = IW'(j);
    end
    any_match  = |match;
    any_valid  = |valid_q;
    more_valid = |(valid_q & ~(DEPTH'(1) << first_idx));
  end

  // Sequencer: one result word per cycle at most.
  always_comb begin
    state_d      = state_q;
    reply_addr_d = reply_addr_q;
    cmd_pop_o    = 1'b0;
    res_push_o   = 1'b0;
    res_o.kind   = KIND_WRITE;
    res_o.addr   = to_line(addr_q[0]);
    res_o.hit    = 1'b0;
    res_o.last   = 1'b1;
    shift_en     = 1'b0;
    shift_base   = '0;
    tail_wr      = 1'b0;
    clr_en       = 1'b0;
    unique case (state_q)
      ST_REPLY: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.kind = KIND_REPLY;
          res_o.addr = reply_addr_q;
          res_o.hit  = 1'b1;
          state_d    = ST_RUN;
        end
      end
      default: begin
        if (go) begin
          unique case (cmd_i.op)
            OP_INSERT: begin
              cmd_pop_o = 1'b1;
              if (!any_match) begin
                tail_wr = 1'b1;
                // Full tail: drain the head and shift to make room.
                if (valid_q[DEPTH-1]) begin
                  shift_en   = 1'b1;
                  res_push_o = valid_q[0];
                end
              end
            end
            OP_CHECK: begin
              cmd_pop_o = 1'b1;
              if (any_match && cmd_i.write_out) begin
                shift_en     = 1'b1;
                shift_base   = match_idx;
                res_push_o   = 1'b1;
                res_o.addr   = to_line(cmd_addr);
                res_o.last   = 1'b0;
                reply_addr_d = to_line(cmd_addr);
                state_d      = ST_REPLY;
              end else begin
                res_push_o = 1'b1;
                res_o.kind = KIND_REPLY;
                res_o.addr = to_line(cmd_addr);
                res_o.hit  = any_match;
              end
            end
            OP_CLEAR: begin
              // Write out the lowest valid slot per cycle while the result queue has room;
              // hold the command until the last one is gone.
              if (any_valid) begin
                res_push_o = 1'b1;
                res_o.addr = to_line(addr_q[first_idx]);
                res_o.last = !more_valid;
                clr_en     = 1'b1;
                cmd_pop_o  = !more_valid;
              end else begin
                cmd_pop_o = 1'b1;
              end
            end
            default: begin
              cmd_pop_o  = 1'b1;
              shift_en   = 1'b1;
              res_push_o = valid_q[0];
            end
          endcase
        end
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (shift_en) begin
      for (int j = 0; j < DEPTH - 1; j++) begin
        if (IW'(j) >= shift_base) valid_d[j] = valid_q[j+1];
      end
      valid_d[DEPTH-1] = 1'b0;
    end
    if (tail_wr) valid_d[DEPTH-1] = 1'b1;
    if (clr_en)  valid_d[first_idx] = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int j = 0; j < DEPTH - 1; j++) begin
        if (IW'(j) >= shift_base) addr_q[j] <= addr_q[j+1];
      end
    end
    if (tail_wr) addr_q[DEPTH-1] <= cmd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      valid_q      <= '0;
      reply_addr_q <= '0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      reply_addr_q <= reply_addr_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/coalescing_write_buffer.sv @@
// Top level of the coalescing write buffer: front queue, engine, result queue.
// Depends on cwb_pkg, cwb_front, cwb_engine and cwb_result_q.
//
// The buffer holds up to DEPTH evicted line addresses in a shift register,
// slot 0 the head. Push a word with command 0 to insert (merge with a match,
// else take the tail, else write the head to memory and shift), 1 to check
// (one reply word; with write_out set and a hit, first a memory write word and
// the entry is removed), 2 to clear (a memory write word per valid slot in
// slot order) or 3 to drain the head. Every result word carries kind, address,
// hit and last; last marks the final word an input caused, and a command that
// causes nothing yields no word. The engine issues at most one result word per
// cycle into its two-entry result queue and waits while that queue is full. A
// check that removes an entry first issues its memory write word and then its
// reply word; clear issues one memory write word per valid slot and holds the
// command until the last one is gone. The first result word of an accepted
// input is registered in the two-entry command queue, passes through the
// engine and is registered in the two-entry result queue before it shows on
// the result ports. Addresses are compared on their low ADDRESS_BITS bits.
`default_nettype none

module coalescing_write_buffer
  import cwb_pkg::*;
#(
  parameter int unsigned DEPTH        = 8,
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        command_i,
  input  wire logic [LINE_W-1:0] line_address_i,
  input  wire logic              write_out_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   kind_o,
  output logic [LINE_W-1:0]      result_address_o,
  output logic                   hit_o,
  output logic                   last_o
);

  logic cmd_valid, cmd_pop, res_full, res_push;
  cmd_t cmd;
  res_t res_in, res_out;

  // Accept and decode input words.
  cwb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .command_i      (command_i),
    .line_address_i (line_address_i),
    .write_out_i    (write_out_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  // Carry out commands against the buffer.
  cwb_engine #(
    .DEPTH        (DEPTH),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Hold result words until the consumer pops them.
  cwb_result_q u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign kind_o           = res_out.kind;
  assign result_address_o = res_out.addr;
  assign hit_o            = res_out.hit;
  assign last_o           = res_out.last;

endmodule

`default_nettype wire
